FILE: rtl/ofrm_pkg.sv
package ofrm_pkg;

    localparam int InW      = 32;
    localparam int FracBits = 30;
    localparam int OutW     = FracBits + 2;
    localparam int QW       = FracBits + 1;
    localparam int PW       = 2 * InW;
    localparam int MagW     = 3 * InW;
    localparam int SqW      = 2 * MagW;
    localparam int SumW     = SqW + 2;
    localparam int YW       = SumW + FracBits + 2;
    localparam int DW       = SumW + 2 * FracBits + 6;
    localparam int Lanes    = 9;
    localparam int Steps    = FracBits + 1;
    localparam int BitW     = $clog2(Steps);
    localparam int ShW      = BitW + 2;

    localparam logic [1:0] FrameVvlh = 2'd0;
    localparam logic [1:0] FrameLvlh = 2'd1;
    localparam logic [1:0] FrameVnc  = 2'd2;

    localparam logic [OutW-1:0] QOne = OutW'(1) << FracBits;

    typedef struct packed {
        logic [1:0] kind;
        logic       to_local;
        logic       degen;
    } t_ctl;

    // lanes 0..2: rejection axis, 3..5: p x v, 6..8: reference vector
    typedef struct packed {
        logic [Lanes-1:0][MagW-1:0] mag;
        logic [Lanes-1:0]           neg;
        t_ctl                       ctl;
    } t_axes;

    typedef struct packed {
        logic [Lanes-1:0][DW-1:0] d;
        logic [Lanes-1:0][YW-1:0] y;
        logic [2:0][SumW-1:0]     s;
        logic [Lanes-1:0][QW-1:0] q;
        logic [Lanes-1:0]         neg;
        t_ctl                     ctl;
    } t_root;

endpackage

FILE: rtl/ofrm_vec.sv
module ofrm_vec
    import ofrm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0][InW-1:0] i_pos,
    input  logic [2:0][InW-1:0] i_vel,
    input  logic [1:0]          i_kind,
    input  logic                i_to_local,
    output logic                o_valid,
    input  logic                i_stall,
    output t_axes               o_axes
);

    localparam int NStg = 5;
    localparam int CW   = PW + 1;
    localparam int BaW  = PW + 2;

    logic [NStg-1:0] r_vld;
    logic [NStg:0]   stl;

    // stage 1: cross and dot partial products
    logic                  is_vnc;
    logic [2:0][InW-1:0]   a_in, b_in;
    logic signed [PW-1:0]  n1_cp [3], n1_cn [3], n1_bb [3], n1_ba [3];
    logic signed [PW-1:0]  r1_cp [3], r1_cn [3], r1_bb [3], r1_ba [3];
    logic [2:0][InW-1:0]   r1_a, r1_b;
    t_ctl                  r1_ctl;

    // stage 2: sums
    logic signed [CW-1:0]  n2_c [3];
    logic [PW-1:0]         n2_bb;
    logic signed [BaW-1:0] n2_ba;
    logic                  n2_zero;
    logic signed [CW-1:0]  r2_c [3];
    logic [PW-1:0]         r2_bb;
    logic signed [BaW-1:0] r2_ba;
    logic [2:0][InW-1:0]   r2_a, r2_b;
    t_ctl                  r2_ctl;

    // stage 3: magnitude products of the rejection terms
    logic [InW-1:0]        amag [3], bmag [3];
    logic [PW-1:0]         bamag;
    logic [PW-1:0]         n3_p1l [3], n3_p1h [3], n3_p2l [3], n3_p2h [3];
    logic [PW-1:0]         n3_cmag [3];
    logic [2:0]            n3_e1, n3_e2, n3_cneg, n3_bneg;
    logic [PW-1:0]         r3_p1l [3], r3_p1h [3], r3_p2l [3], r3_p2h [3];
    logic [PW-1:0]         r3_cmag [3];
    logic [InW-1:0]        r3_bmag [3];
    logic [2:0]            r3_e1, r3_e2, r3_cneg, r3_bneg;
    t_ctl                  r3_ctl;

    // stage 4: term magnitudes
    logic [MagW-1:0]       r4_x1 [3], r4_x2 [3];
    logic [PW-1:0]         r4_cmag [3];
    logic [InW-1:0]        r4_bmag [3];
    logic [2:0]            r4_e1, r4_e2, r4_cneg, r4_bneg;
    t_ctl                  r4_ctl;

    // stage 5: signed difference in sign/magnitude form
    logic [MagW-1:0]       sum5 [3], d21 [3];
    logic [MagW:0]         d12 [3];
    t_axes                 n5_axes, r5_axes;

    always_comb begin
        stl[NStg] = i_stall;
        for (int k = NStg - 1; k >= 0; k--) begin
            stl[k] = r_vld[k] & stl[k+1];
        end
    end

    assign o_stall = stl[0];
    assign o_valid = r_vld[NStg-1];
    assign o_axes  = r5_axes;

    always_comb begin
        is_vnc = !((i_kind == FrameVvlh) || (i_kind == FrameLvlh));
        for (int i = 0; i < 3; i++) begin
            a_in[i] = is_vnc ? i_pos[i] : i_vel[i];
            b_in[i] = is_vnc ? i_vel[i] : i_pos[i];
        end
        n1_cp[0] = $signed(i_pos[1]) * $signed(i_vel[2]);
        n1_cn[0] = $signed(i_pos[2]) * $signed(i_vel[1]);
        n1_cp[1] = $signed(i_pos[2]) * $signed(i_vel[0]);
        n1_cn[1] = $signed(i_pos[0]) * $signed(i_vel[2]);
        n1_cp[2] = $signed(i_pos[0]) * $signed(i_vel[1]);
        n1_cn[2] = $signed(i_pos[1]) * $signed(i_vel[0]);
        for (int i = 0; i < 3; i++) begin
            n1_bb[i] = $signed(b_in[i]) * $signed(b_in[i]);
            n1_ba[i] = $signed(b_in[i]) * $signed(a_in[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_c[i] = {r1_cp[i][PW-1], r1_cp[i]} - {r1_cn[i][PW-1], r1_cn[i]};
        end
        n2_bb   = r1_bb[0] + r1_bb[1] + r1_bb[2];
        n2_ba   = BaW'(r1_ba[0]) + BaW'(r1_ba[1]) + BaW'(r1_ba[2]);
        n2_zero = (n2_c[0] == '0) && (n2_c[1] == '0) && (n2_c[2] == '0);
    end

    always_comb begin
        bamag = r2_ba[BaW-1] ? PW'(-r2_ba) : PW'(r2_ba);
        for (int i = 0; i < 3; i++) begin
            amag[i]    = r2_a[i][InW-1] ? (~r2_a[i] + 1'b1) : r2_a[i];
            bmag[i]    = r2_b[i][InW-1] ? (~r2_b[i] + 1'b1) : r2_b[i];
            n3_p1l[i]  = amag[i] * r2_bb[InW-1:0];
            n3_p1h[i]  = amag[i] * r2_bb[PW-1:InW];
            n3_p2l[i]  = bmag[i] * bamag[InW-1:0];
            n3_p2h[i]  = bmag[i] * bamag[PW-1:InW];
            n3_e1[i]   = r2_a[i][InW-1];
            n3_e2[i]   = ~(r2_b[i][InW-1] ^ r2_ba[BaW-1]);
            n3_cmag[i] = r2_c[i][CW-1] ? PW'(-r2_c[i]) : PW'(r2_c[i]);
            n3_cneg[i] = r2_c[i][CW-1];
            n3_bneg[i] = r2_b[i][InW-1];
        end
    end

    always_comb begin
        n5_axes.ctl = r4_ctl;
        for (int i = 0; i < 3; i++) begin
            sum5[i] = r4_x1[i] + r4_x2[i];
            d12[i]  = {1'b0, r4_x1[i]} - {1'b0, r4_x2[i]};
            d21[i]  = r4_x2[i] - r4_x1[i];
            if (r4_e1[i] == r4_e2[i]) begin
                n5_axes.mag[i] = sum5[i];
                n5_axes.neg[i] = r4_e1[i];
            end else if (!d12[i][MagW]) begin
                n5_axes.mag[i] = d12[i][MagW-1:0];
                n5_axes.neg[i] = r4_e1[i];
            end else begin
                n5_axes.mag[i] = d21[i];
                n5_axes.neg[i] = r4_e2[i];
            end
            n5_axes.mag[3+i] = MagW'(r4_cmag[i]);
            n5_axes.neg[3+i] = r4_cneg[i];
            n5_axes.mag[6+i] = MagW'(r4_bmag[i]);
            n5_axes.neg[6+i] = r4_bneg[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (!stl[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NStg; k++) begin
                if (!stl[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stl[0]) begin
            r1_cp           <= n1_cp;
            r1_cn           <= n1_cn;
            r1_bb           <= n1_bb;
            r1_ba           <= n1_ba;
            r1_a            <= a_in;
            r1_b            <= b_in;
            r1_ctl.kind     <= i_kind;
            r1_ctl.to_local <= i_to_local;
            r1_ctl.degen    <= 1'b0;
        end
        if (!stl[1]) begin
            r2_c            <= n2_c;
            r2_bb           <= n2_bb;
            r2_ba           <= n2_ba;
            r2_a            <= r1_a;
            r2_b            <= r1_b;
            r2_ctl.kind     <= r1_ctl.kind;
            r2_ctl.to_local <= r1_ctl.to_local;
            r2_ctl.degen    <= n2_zero;
        end
        if (!stl[2]) begin
            r3_p1l  <= n3_p1l;
            r3_p1h  <= n3_p1h;
            r3_p2l  <= n3_p2l;
            r3_p2h  <= n3_p2h;
            r3_cmag <= n3_cmag;
            r3_bmag <= bmag;
            r3_e1   <= n3_e1;
            r3_e2   <= n3_e2;
            r3_cneg <= n3_cneg;
            r3_bneg <= n3_bneg;
            r3_ctl  <= r2_ctl;
        end
        if (!stl[3]) begin
            for (int i = 0; i < 3; i++) begin
                r4_x1[i] <= {r3_p1h[i], {InW{1'b0}}} + MagW'(r3_p1l[i]);
                r4_x2[i] <= {r3_p2h[i], {InW{1'b0}}} + MagW'(r3_p2l[i]);
            end
            r4_cmag <= r3_cmag;
            r4_bmag <= r3_bmag;
            r4_e1   <= r3_e1;
            r4_e2   <= r3_e2;
            r4_cneg <= r3_cneg;
            r4_bneg <= r3_bneg;
            r4_ctl  <= r3_ctl;
        end
        if (!stl[4]) begin
            r5_axes <= n5_axes;
        end
    end

endmodule

FILE: rtl/ofrm_sq.sv
module ofrm_sq
    import ofrm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_axes i_axes,
    output logic  o_valid,
    input  logic  i_stall,
    output t_root o_root
);

    localparam int NStg = 4;

    logic [NStg-1:0] r_vld;
    logic [NStg:0]   stl;

    // partial products: 00, 11, 22, 01, 02, 12
    logic [InW-1:0]   dg [Lanes][3];
    logic [PW-1:0]    n1_pp [Lanes][6];
    logic [PW-1:0]    r1_pp [Lanes][6];
    logic [Lanes-1:0] r1_neg, r2_neg, r3_neg;
    t_ctl             r1_ctl, r2_ctl, r3_ctl;

    logic [SqW-1:0]   n2_sq [Lanes];
    logic [SqW-1:0]   r2_sq [Lanes], r3_sq [Lanes];
    logic [SumW-1:0]  n3_s [3];
    logic [SumW-1:0]  r3_s [3];
    t_root            n4_root, r4_root;

    always_comb begin
        stl[NStg] = i_stall;
        for (int k = NStg - 1; k >= 0; k--) begin
            stl[k] = r_vld[k] & stl[k+1];
        end
    end

    assign o_stall = stl[0];
    assign o_valid = r_vld[NStg-1];
    assign o_root  = r4_root;

    always_comb begin
        for (int l = 0; l < Lanes; l++) begin
            for (int j = 0; j < 3; j++) begin
                dg[l][j] = i_axes.mag[l][j*InW +: InW];
            end
            n1_pp[l][0] = dg[l][0] * dg[l][0];
            n1_pp[l][1] = dg[l][1] * dg[l][1];
            n1_pp[l][2] = dg[l][2] * dg[l][2];
            n1_pp[l][3] = dg[l][0] * dg[l][1];
            n1_pp[l][4] = dg[l][0] * dg[l][2];
            n1_pp[l][5] = dg[l][1] * dg[l][2];
        end
    end

    // cross terms are doubled by the extra shift bit
    always_comb begin
        for (int l = 0; l < Lanes; l++) begin
            n2_sq[l] = {r1_pp[l][2], r1_pp[l][1], r1_pp[l][0]}
                     + SqW'({r1_pp[l][5], r1_pp[l][3], {(InW+1){1'b0}}})
                     + SqW'({r1_pp[l][4], {(PW+1){1'b0}}});
        end
    end

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            n3_s[v] = SumW'(r2_sq[3*v]) + SumW'(r2_sq[3*v+1]) + SumW'(r2_sq[3*v+2]);
        end
    end

    // start of root search: D = 4^(F+1) a^2 - s, Y = -s, q = 0
    always_comb begin
        n4_root.ctl = r3_ctl;
        n4_root.neg = r3_neg;
        for (int v = 0; v < 3; v++) begin
            n4_root.s[v] = r3_s[v];
            for (int k = 0; k < 3; k++) begin
                n4_root.d[3*v+k] = (DW'(r3_sq[3*v+k]) << (2 * FracBits + 2))
                                 - DW'(r3_s[v]);
                n4_root.y[3*v+k] = YW'(0) - YW'(r3_s[v]);
                n4_root.q[3*v+k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (!stl[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NStg; k++) begin
                if (!stl[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stl[0]) begin
            r1_pp  <= n1_pp;
            r1_neg <= i_axes.neg;
            r1_ctl <= i_axes.ctl;
        end
        if (!stl[1]) begin
            r2_sq  <= n2_sq;
            r2_neg <= r1_neg;
            r2_ctl <= r1_ctl;
        end
        if (!stl[2]) begin
            r3_sq  <= r2_sq;
            r3_s   <= n3_s;
            r3_neg <= r2_neg;
            r3_ctl <= r2_ctl;
        end
        if (!stl[3]) begin
            r4_root <= n4_root;
        end
    end

endmodule

FILE: rtl/ofrm_step.sv
module ofrm_step
    import ofrm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [BitW-1:0] i_bit,
    input  t_root           i_root,
    output logic            o_valid,
    input  logic            i_stall,
    output t_root           o_root
);

    // one bit of q: try q + 2^b, i.e. X grows by 2^(b+2) Y + 2^(2b+2) s
    logic             r_vld;
    t_root            r_root, n_root;
    logic [ShW-1:0]   sh_y, sh_s, sh_u;
    logic [DW-1:0]    inc [Lanes];
    logic [DW-1:0]    diff [Lanes];
    logic [Lanes-1:0] acc;

    assign o_stall = r_vld & i_stall;
    assign o_valid = r_vld;
    assign o_root  = r_root;

    always_comb begin
        sh_y   = ShW'(i_bit) + ShW'(2);
        sh_s   = (ShW'(i_bit) << 1) + ShW'(2);
        sh_u   = ShW'(i_bit) + ShW'(1);
        n_root = i_root;
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                inc[3*v+k]  = ({{(DW-YW){i_root.y[3*v+k][YW-1]}}, i_root.y[3*v+k]} << sh_y)
                            + (DW'(i_root.s[v]) << sh_s);
                diff[3*v+k] = i_root.d[3*v+k] - inc[3*v+k];
                // q already at full scale takes no more bits
                acc[3*v+k]  = !diff[3*v+k][DW-1] && !i_root.q[3*v+k][FracBits];
                if (acc[3*v+k]) begin
                    n_root.d[3*v+k] = diff[3*v+k];
                    n_root.y[3*v+k] = i_root.y[3*v+k] + (YW'(i_root.s[v]) << sh_u);
                    n_root.q[3*v+k] = i_root.q[3*v+k] | (QW'(1) << i_bit);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_root <= n_root;
        end
    end

endmodule

FILE: rtl/orbit_frame_rotation_matrix.sv
// Pipeline: an accepted input beat passes 5 vector stages, 4 squaring/norm
// stages, 31 root bit stages and 1 output stage before its result is on o_valid.
// Throughput: one beat per cycle; each stage holds only while the one after
// it is full and stalled, so bubbles are squeezed out.
// Reset: synchronous, active low; clears the valid bits only.
module orbit_frame_rotation_matrix
    import ofrm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [InW-1:0]  i_pos_x,
    input  logic signed [InW-1:0]  i_pos_y,
    input  logic signed [InW-1:0]  i_pos_z,
    input  logic signed [InW-1:0]  i_vel_x,
    input  logic signed [InW-1:0]  i_vel_y,
    input  logic signed [InW-1:0]  i_vel_z,
    input  logic [1:0]             i_frame_kind,
    input  logic                   i_to_local,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [OutW-1:0] o_m00,
    output logic signed [OutW-1:0] o_m01,
    output logic signed [OutW-1:0] o_m02,
    output logic signed [OutW-1:0] o_m10,
    output logic signed [OutW-1:0] o_m11,
    output logic signed [OutW-1:0] o_m12,
    output logic signed [OutW-1:0] o_m20,
    output logic signed [OutW-1:0] o_m21,
    output logic signed [OutW-1:0] o_m22,
    output logic                   o_degenerate
);

    localparam logic [1:0] VecW = 2'd0;
    localparam logic [1:0] VecC = 2'd1;
    localparam logic [1:0] VecP = 2'd2;

    logic             vec_vld, vec_stl;
    t_axes            vec_axes;
    logic             sq_vld;
    t_root            root_q [Steps+1];
    logic [Steps:0]   vld_q;
    logic [Steps:0]   stl_q;

    logic             is_vvlh;
    logic [OutW-1:0]  mq;
    logic             ng;
    logic [OutW-1:0]  ent [3][3];
    logic [1:0]       rowv [3];
    logic [OutW-1:0]  mat [3][3];
    logic [OutW-1:0]  n_m [3][3];
    logic [OutW-1:0]  r_m [3][3];
    logic             r_degen;
    logic             r_ovld;
    t_root            fin;

    ofrm_vec u_vec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pos      ({i_pos_z, i_pos_y, i_pos_x}),
        .i_vel      ({i_vel_z, i_vel_y, i_vel_x}),
        .i_kind     (i_frame_kind),
        .i_to_local (i_to_local),
        .o_valid    (vec_vld),
        .i_stall    (vec_stl),
        .o_axes     (vec_axes)
    );

    ofrm_sq u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vec_vld),
        .o_stall (vec_stl),
        .i_axes  (vec_axes),
        .o_valid (sq_vld),
        .i_stall (stl_q[0]),
        .o_root  (root_q[0])
    );

    assign vld_q[0] = sq_vld;

    for (genvar g = 0; g < Steps; g++) begin : g_step
        ofrm_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld_q[g]),
            .o_stall (stl_q[g]),
            .i_bit   (BitW'(FracBits - g)),
            .i_root  (root_q[g]),
            .o_valid (vld_q[g+1]),
            .i_stall (stl_q[g+1]),
            .o_root  (root_q[g+1])
        );
    end

    assign fin          = root_q[Steps];
    assign stl_q[Steps] = r_ovld & i_stall;

    always_comb begin
        is_vvlh = (fin.ctl.kind == FrameVvlh);
        mq      = '0;
        ng      = 1'b0;
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                mq        = OutW'(fin.q[3*v+k]);
                // VVLH uses -c and -p as its second and third axes
                ng        = fin.neg[3*v+k] ^ (is_vvlh && (v != 0));
                ent[v][k] = ng ? (OutW'(0) - mq) : mq;
            end
        end
        case (fin.ctl.kind)
            FrameVvlh: rowv = '{VecW, VecC, VecP};
            FrameLvlh: rowv = '{VecP, VecW, VecC};
            default:   rowv = '{VecP, VecC, VecW};
        endcase
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                if (fin.ctl.degen) begin
                    mat[r][k] = (r == k) ? QOne : '0;
                end else begin
                    mat[r][k] = ent[rowv[r]][k];
                end
            end
        end
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_m[r][k] = fin.ctl.to_local ? mat[r][k] : mat[k][r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (!stl_q[Steps]) begin
            r_ovld <= vld_q[Steps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stl_q[Steps]) begin
            r_m     <= n_m;
            r_degen <= fin.ctl.degen;
        end
    end

    assign o_valid      = r_ovld;
    assign o_degenerate = r_degen;
    assign o_m00        = r_m[0][0];
    assign o_m01        = r_m[0][1];
    assign o_m02        = r_m[0][2];
    assign o_m10        = r_m[1][0];
    assign o_m11        = r_m[1][1];
    assign o_m12        = r_m[1][2];
    assign o_m20        = r_m[2][0];
    assign o_m21        = r_m[2][1];
    assign o_m22        = r_m[2][2];

endmodule
